// File: sv/modbus_soil_frame_averager_assert.svh
// assertion macros for the modbus soil frame averager
// expects clk and rst_n in the including module's scope
`ifndef MODBUS_SOIL_FRAME_AVERAGER_ASSERT_SVH
`define MODBUS_SOIL_FRAME_AVERAGER_ASSERT_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define MSFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds in this cycle, consequent in the next cycle
`define MSFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/msfa_pkg.sv
// types, constants and the crc step for the modbus soil frame averager
// no dependencies
`timescale 1ns / 1ps

package msfa_pkg;

    localparam int CAP_DEPTH = 17;
    localparam int NUM_QTY = 7;
    localparam int NUM_NZ = 4;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] ACID_DEFAULT = 16'd70;
    localparam logic [2:0] REG_CNT_RESET = 3'd7;
    localparam logic [2:0] REG_CNT_3 = 3'd3;
    localparam logic [2:0] REG_CNT_4 = 3'd4;
    localparam logic [14:0] MOIST_HI = 15'd1000;
    localparam logic [14:0] TEMP_HI = 15'd800;
    localparam logic [14:0] COND_HI = 15'd20000;
    localparam logic [14:0] ACID_LO = 15'd30;
    localparam logic [14:0] ACID_HI = 15'd90;

    localparam logic [2:0] Q_MOIST = 3'd0;
    localparam logic [2:0] Q_TEMP = 3'd1;
    localparam logic [2:0] Q_COND = 3'd2;
    localparam logic [2:0] Q_ACID = 3'd3;
    localparam logic [2:0] Q_LAST = 3'd6;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic        crc_ok;
        logic        reading_valid;
        logic [15:0] moisture_tenths;
        logic [15:0] temperature_tenths;
        logic [15:0] conductivity;
        logic [15:0] acidity_tenths;
        logic [15:0] nitrogen_avg;
        logic [15:0] phosphorus_avg;
        logic [15:0] potassium_avg;
    } out_item_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WRITE = 6'b000010,
        S_SCAN  = 6'b000100,
        S_LOAD  = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: sv/modbus_soil_frame_averager.sv
// top level of the modbus soil frame averager
// depends on msfa_pkg and modbus_soil_frame_averager_assert.svh
`timescale 1ns / 1ps

// Takes a Modbus RTU read-holding-registers reply one byte per transaction,
// checks CRC-16/Modbus and, on a good frame, stores the words into sample rings
// of SAMPLE_DEPTH rows and reports truncated averages with a range check.
// A bad final byte gives its result the next cycle. A good final byte takes a
// ring write, a ring scan through the single memory read port, then 7
// divisions on one shared restoring divider, each a load step followed by the
// shift-subtract steps, then a load of the output register. A final byte waits
// while a result is still held.
// Rings read as their reset values until written; there is no clearing pass.
module modbus_soil_frame_averager #(
    parameter int SAMPLE_DEPTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  msfa_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output msfa_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_wdata
);

`include "modbus_soil_frame_averager_assert.svh"

    localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1);
    localparam int IDX_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int SUM_W = 16 + CNT_W;
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam int LIM_W = 15 + CNT_W;
    localparam int ROW_W = 16 * msfa_pkg::NUM_QTY;

    msfa_pkg::state_t state_reg, state_next;

    logic [2:0]  cfg_reg;
    logic [4:0]  pos_reg;
    logic [15:0] crc_reg;
    logic [7:0]  cap_reg [msfa_pkg::CAP_DEPTH];
    logic [IDX_W-1:0] ptr_reg;
    logic [SAMPLE_DEPTH-1:0] row_valid_reg;

    logic [ROW_W-1:0] ring_mem [SAMPLE_DEPTH];
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_valid_reg;
    logic [CNT_W-1:0] issue_reg;
    logic             pend_reg;

    logic [SUM_W-1:0] sum_reg [msfa_pkg::NUM_QTY];
    logic [CNT_W-1:0] cnt_reg [msfa_pkg::NUM_NZ];
    logic [15:0]      avg_reg [msfa_pkg::NUM_QTY];
    logic             ok_reg;
    logic [2:0]       q_reg;

    logic [CNT_W:0]    rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [DCNT_W-1:0] dcnt_reg;

    logic        out_valid_reg;
    msfa_pkg::out_item_t out_reg;

    logic        mode3, mode7;
    logic [4:0]  pos_eff;
    logic [15:0] crc_base, crc_new;
    logic [4:0]  last_pos;
    logic        is_last;
    logic        in_acc;
    logic [ROW_W-1:0] wr_row;
    logic [ROW_W-1:0] rd_row;
    logic [15:0] word_v [msfa_pkg::NUM_QTY];
    logic [14:0] lim_hi;
    logic [LIM_W-1:0] prod_hi, prod_lo;
    logic        range_bad;
    logic [CNT_W:0] shifted;
    logic        fits;

    assign mode3 = (cfg_reg == msfa_pkg::REG_CNT_3);
    assign mode7 = !mode3 && (cfg_reg != msfa_pkg::REG_CNT_4);

    assign pos_eff  = in_data.frame_start ? 5'd0 : pos_reg;
    assign crc_base = in_data.frame_start ? msfa_pkg::CRC_INIT : crc_reg;
    assign crc_new  = msfa_pkg::crc_byte(crc_base, in_data.rx_byte);
    assign last_pos = mode3 ? 5'd10 : (mode7 ? 5'd18 : 5'd12);
    assign is_last  = (pos_eff >= last_pos);

    assign in_stall  = (state_reg != msfa_pkg::S_IDLE) || (out_valid_reg && is_last);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        for (int k = 0; k < msfa_pkg::NUM_QTY; k++)
            word_v[k] = {cap_reg[3 + 2 * k], cap_reg[4 + 2 * k]};
        wr_row = '0;
        wr_row[15:0]  = word_v[0];
        wr_row[31:16] = word_v[1];
        wr_row[47:32] = word_v[2];
        wr_row[63:48] = mode3 ? msfa_pkg::ACID_DEFAULT : word_v[3];
        if (mode7)
            wr_row[111:64] = {word_v[6], word_v[5], word_v[4]};
        rd_row = rd_data_reg;
        if (!rd_valid_reg)
        begin
            rd_row = '0;
            rd_row[63:48] = msfa_pkg::ACID_DEFAULT;
        end
    end

    // range check for the quantity being loaded into the divider
    always_comb
    begin
        case (q_reg)
            msfa_pkg::Q_MOIST: lim_hi = msfa_pkg::MOIST_HI;
            msfa_pkg::Q_TEMP:  lim_hi = msfa_pkg::TEMP_HI;
            msfa_pkg::Q_COND:  lim_hi = msfa_pkg::COND_HI;
            msfa_pkg::Q_ACID:  lim_hi = msfa_pkg::ACID_HI;
            default:           lim_hi = msfa_pkg::COND_HI;
        endcase
        prod_hi = LIM_W'(lim_hi) * LIM_W'(cnt_reg[q_reg[1:0]]);
        prod_lo = LIM_W'(msfa_pkg::ACID_LO) * LIM_W'(cnt_reg[q_reg[1:0]]);
        range_bad = (32'(sum_reg[q_reg]) > 32'(prod_hi));
        if (q_reg == msfa_pkg::Q_ACID)
            range_bad = range_bad || (cnt_reg[3] == '0)
                        || (32'(sum_reg[q_reg]) < 32'(prod_lo));
        if (q_reg > msfa_pkg::Q_ACID || (q_reg == msfa_pkg::Q_ACID && mode3))
            range_bad = 1'b0;
    end

    assign shifted = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            msfa_pkg::S_IDLE:
                if (in_acc && is_last && crc_new == 16'h0000)
                    state_next = msfa_pkg::S_WRITE;
            msfa_pkg::S_WRITE:
                state_next = msfa_pkg::S_SCAN;
            msfa_pkg::S_SCAN:
                if (issue_reg == CNT_W'(SAMPLE_DEPTH) && !pend_reg)
                    state_next = msfa_pkg::S_LOAD;
            msfa_pkg::S_LOAD:
                state_next = msfa_pkg::S_DIV;
            msfa_pkg::S_DIV:
                if (dcnt_reg == '0)
                    state_next = (q_reg == msfa_pkg::Q_LAST) ? msfa_pkg::S_OUT
                                                             : msfa_pkg::S_LOAD;
            msfa_pkg::S_OUT:
                state_next = msfa_pkg::S_IDLE;
            default:
                state_next = msfa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msfa_pkg::S_IDLE;
            cfg_reg       <= msfa_pkg::REG_CNT_RESET;
            pos_reg       <= '0;
            crc_reg       <= msfa_pkg::CRC_INIT;
            ptr_reg       <= '0;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            q_reg         <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                cfg_reg <= cfg_wdata;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                msfa_pkg::S_IDLE:
                    if (in_acc)
                    begin
                        if (is_last)
                        begin
                            pos_reg <= '0;
                            crc_reg <= msfa_pkg::CRC_INIT;
                            if (crc_new != 16'h0000)
                                out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            pos_reg <= pos_eff + 5'd1;
                            crc_reg <= crc_new;
                        end
                    end
                msfa_pkg::S_WRITE:
                begin
                    row_valid_reg[ptr_reg] <= 1'b1;
                    ptr_reg   <= (ptr_reg == IDX_W'(SAMPLE_DEPTH - 1)) ? '0
                                                                     : ptr_reg + 1'b1;
                    issue_reg <= '0;
                    pend_reg  <= 1'b0;
                    q_reg     <= '0;
                end
                msfa_pkg::S_SCAN:
                begin
                    if (issue_reg != CNT_W'(SAMPLE_DEPTH))
                    begin
                        rd_valid_reg <= row_valid_reg[issue_reg[IDX_W-1:0]];
                        issue_reg    <= issue_reg + 1'b1;
                        pend_reg     <= 1'b1;
                    end
                    else
                        pend_reg <= 1'b0;
                end
                msfa_pkg::S_LOAD:
                    dcnt_reg <= DCNT_W'(SUM_W);
                msfa_pkg::S_DIV:
                begin
                    if (dcnt_reg != '0)
                        dcnt_reg <= dcnt_reg - 1'b1;
                    else
                        q_reg <= q_reg + 3'd1;
                end
                msfa_pkg::S_OUT:
                    out_valid_reg <= 1'b1;
                default:
                    pos_reg <= '0;
            endcase
        end
    end

    // frame capture, accumulators, divider and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == msfa_pkg::S_IDLE && in_acc)
        begin
            if (pos_eff < 5'(msfa_pkg::CAP_DEPTH))
                cap_reg[pos_eff] <= in_data.rx_byte;
            if (is_last && crc_new != 16'h0000)
                out_reg <= '0;
        end
        if (state_reg == msfa_pkg::S_WRITE)
        begin
            for (int k = 0; k < msfa_pkg::NUM_QTY; k++)
                sum_reg[k] <= '0;
            for (int k = 0; k < msfa_pkg::NUM_NZ; k++)
                cnt_reg[k] <= '0;
            ok_reg <= 1'b1;
        end
        if (state_reg == msfa_pkg::S_SCAN && pend_reg)
        begin
            for (int k = 0; k < msfa_pkg::NUM_QTY; k++)
                sum_reg[k] <= sum_reg[k] + SUM_W'(rd_row[16 * k +: 16]);
            for (int k = 0; k < msfa_pkg::NUM_NZ; k++)
                if (rd_row[16 * k +: 16] != 16'h0000)
                    cnt_reg[k] <= cnt_reg[k] + 1'b1;
        end
        if (state_reg == msfa_pkg::S_LOAD)
        begin
            rem_reg <= '0;
            quo_reg <= sum_reg[q_reg];
            dvs_reg <= (q_reg > msfa_pkg::Q_ACID) ? CNT_W'(SAMPLE_DEPTH)
                                                  : cnt_reg[q_reg[1:0]];
            if (range_bad)
                ok_reg <= 1'b0;
        end
        if (state_reg == msfa_pkg::S_DIV)
        begin
            if (dcnt_reg != '0)
            begin
                if (fits)
                    rem_reg <= shifted - {1'b0, dvs_reg};
                else
                    rem_reg <= shifted;
                quo_reg <= {quo_reg[SUM_W-2:0], fits};
            end
            else
            begin
                if (dvs_reg == '0)
                    avg_reg[q_reg] <= 16'h0000;
                else if (q_reg == msfa_pkg::Q_ACID && mode3)
                    avg_reg[q_reg] <= msfa_pkg::ACID_DEFAULT;
                else if (q_reg > msfa_pkg::Q_ACID && !mode7)
                    avg_reg[q_reg] <= 16'h0000;
                else
                    avg_reg[q_reg] <= quo_reg[15:0];
            end
        end
        if (state_reg == msfa_pkg::S_OUT)
        begin
            out_reg.crc_ok             <= 1'b1;
            out_reg.reading_valid      <= ok_reg;
            out_reg.moisture_tenths    <= avg_reg[0];
            out_reg.temperature_tenths <= avg_reg[1];
            out_reg.conductivity       <= avg_reg[2];
            out_reg.acidity_tenths     <= avg_reg[3];
            out_reg.nitrogen_avg       <= avg_reg[4];
            out_reg.phosphorus_avg     <= avg_reg[5];
            out_reg.potassium_avg      <= avg_reg[6];
        end
    end

    // sample ring memory, one row holds all quantities of one frame
    always_ff @(posedge clk)
    begin
        if (state_reg == msfa_pkg::S_WRITE)
            ring_mem[ptr_reg] <= wr_row;
        rd_data_reg <= ring_mem[issue_reg[IDX_W-1:0]];
    end

    `MSFA_ASSERT_NOW(a_busy_stalls, state_reg != msfa_pkg::S_IDLE, in_stall,
                     "input taken while busy")
    `MSFA_ASSERT_NEXT(a_write_then_scan, state_reg == msfa_pkg::S_WRITE,
                      state_reg == msfa_pkg::S_SCAN, "ring write not followed by scan")
    `MSFA_ASSERT_NOW(a_issue_bound, state_reg == msfa_pkg::S_SCAN,
                     issue_reg <= CNT_W'(SAMPLE_DEPTH), "scan index past ring depth")
    `MSFA_ASSERT_NOW(a_bad_crc_invalid, out_valid_reg && !out_reg.crc_ok,
                     !out_reg.reading_valid, "reading valid after bad crc")

endmodule

// File: tb/modbus_soil_frame_averager_test.sv
// testbench for the modbus soil frame averager: random and directed reply frames
// checked against an in-bench predictor of crc, sample rings and averages
// depends on msfa_pkg and modbus_soil_frame_averager
`timescale 1ns / 1ps

module modbus_soil_frame_averager_test;

    localparam int DEPTH = 8;
    localparam int DRAIN_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 64'd1500000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    msfa_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    msfa_pkg::out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_wdata = '0;

    modbus_soil_frame_averager #(.SAMPLE_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [2:0] reg_count_m;
    int unsigned pos_m;
    logic [15:0] crc_m;
    logic [7:0] capture_m [msfa_pkg::CAP_DEPTH];
    logic [15:0] moist_r [DEPTH];
    logic [15:0] temp_r [DEPTH];
    logic [15:0] cond_r [DEPTH];
    logic [15:0] acid_r [DEPTH];
    logic [15:0] nut_r [3][DEPTH];
    int unsigned ptr_m;

    msfa_pkg::in_item_t pending_bytes [$];
    msfa_pkg::out_item_t expected_readings [$];
    int unsigned sent_bytes = 0;
    int errors = 0;
    longint cycles = 0;
    bit quiet = 1'b0;
    int in_gap = 0;
    int out_gap = 0;
    bit hold_sender = 1'b0;

    function automatic logic [15:0] crc_step(logic [15:0] c_in, logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    function automatic int unsigned regs_active(logic [2:0] rc);
        if (rc == 3'd3) return 3;
        if (rc == 3'd4) return 4;
        return 7;
    endfunction

    function automatic logic [15:0] word_of(int unsigned i);
        return {capture_m[3 + 2 * i], capture_m[4 + 2 * i]};
    endfunction

    task automatic reset_predictor();
        reg_count_m = 3'd7;
        pos_m = 0;
        crc_m = 16'hFFFF;
        ptr_m = 0;
        for (int i = 0; i < msfa_pkg::CAP_DEPTH; i++) capture_m[i] = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            moist_r[i] = '0;
            temp_r[i] = '0;
            cond_r[i] = '0;
            acid_r[i] = 16'd70;
            for (int k = 0; k < 3; k++) nut_r[k][i] = '0;
        end
    endtask

    task automatic nonzero_sum(input logic [15:0] ring [DEPTH], output int unsigned s,
                               output int unsigned c);
        s = 0;
        c = 0;
        for (int i = 0; i < DEPTH; i++)
            if (ring[i] != 0)
            begin
                s += ring[i];
                c++;
            end
    endtask

    task automatic predict_byte(input msfa_pkg::in_item_t it);
        int unsigned n, s, c, p, tot;
        bit ok;
        msfa_pkg::out_item_t r;
        if (it.frame_start)
        begin
            pos_m = 0;
            crc_m = 16'hFFFF;
        end
        if (pos_m < msfa_pkg::CAP_DEPTH) capture_m[pos_m] = it.rx_byte;
        crc_m = crc_step(crc_m, it.rx_byte);
        n = regs_active(reg_count_m);
        if (pos_m < 4 + 2 * n)
        begin
            pos_m++;
            return;
        end
        r = '0;
        if (crc_m == 16'h0000)
        begin
            ok = 1'b1;
            p = ptr_m;
            moist_r[p] = word_of(0);
            temp_r[p] = word_of(1);
            cond_r[p] = word_of(2);
            acid_r[p] = (n >= 4) ? word_of(3) : 16'd70;
            for (int k = 0; k < 3; k++) nut_r[k][p] = (n == 7) ? word_of(4 + k) : 16'd0;
            ptr_m = (p + 1 >= DEPTH) ? 0 : p + 1;
            nonzero_sum(moist_r, s, c);
            r.moisture_tenths = 16'(c ? s / c : 0);
            if (s > 1000 * c) ok = 1'b0;
            nonzero_sum(temp_r, s, c);
            r.temperature_tenths = 16'(c ? s / c : 0);
            if (s > 800 * c) ok = 1'b0;
            nonzero_sum(cond_r, s, c);
            r.conductivity = 16'(c ? s / c : 0);
            if (s > 20000 * c) ok = 1'b0;
            if (n == 3)
                r.acidity_tenths = 16'd70;
            else
            begin
                nonzero_sum(acid_r, s, c);
                r.acidity_tenths = 16'(c ? s / c : 0);
                if (c == 0 || s < 30 * c || s > 90 * c) ok = 1'b0;
            end
            if (n == 7)
            begin
                tot = 0;
                for (int i = 0; i < DEPTH; i++) tot += nut_r[0][i];
                r.nitrogen_avg = 16'(tot / DEPTH);
                tot = 0;
                for (int i = 0; i < DEPTH; i++) tot += nut_r[1][i];
                r.phosphorus_avg = 16'(tot / DEPTH);
                tot = 0;
                for (int i = 0; i < DEPTH; i++) tot += nut_r[2][i];
                r.potassium_avg = 16'(tot / DEPTH);
            end
            r.crc_ok = 1'b1;
            r.reading_valid = ok;
        end
        pos_m = 0;
        crc_m = 16'hFFFF;
        expected_readings.push_back(r);
    endtask

    // build one reply frame; mode 0 plausible, 1 random words, 2 zero words, 3 all ones
    task automatic queue_frame(int unsigned n, int mode, bit corrupt, bit lead_flag);
        logic [7:0] b [$];
        logic [15:0] c, w;
        msfa_pkg::in_item_t it;
        b.push_back(8'($urandom_range(0, 255)));
        b.push_back(8'h03);
        b.push_back(8'(2 * n));
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                0: w = (i == 3) ? 16'($urandom_range(20, 100)) : 16'($urandom_range(0, 1100));
                1: w = 16'($urandom);
                default: w = 16'h0000;
            endcase
            if (mode == 3) w = 16'hFFFF;
            b.push_back(w[15:8]);
            b.push_back(w[7:0]);
        end
        c = 16'hFFFF;
        foreach (b[i]) c = crc_step(c, b[i]);
        if (corrupt) c ^= 16'(1 << $urandom_range(0, 15));
        b.push_back(c[7:0]);
        b.push_back(c[15:8]);
        foreach (b[i])
        begin
            it.rx_byte = b[i];
            it.frame_start = (i == 0) ? lead_flag : 1'b0;
            pending_bytes.push_back(it);
        end
    endtask

    task automatic queue_noise(int cnt);
        msfa_pkg::in_item_t it;
        for (int i = 0; i < cnt; i++)
        begin
            it.rx_byte = 8'($urandom_range(0, 255));
            it.frame_start = $urandom_range(0, 3) == 0;
            pending_bytes.push_back(it);
        end
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || expected_readings.size() != 0 || in_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(logic [2:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        reg_count_m = v;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_byte(in_data);
                sent_bytes++;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (!hold_sender && pending_bytes.size() != 0)
                begin
                    in_data <= pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 11);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_readings.size() == 0)
                begin
                    errors++;
                    if (errors <= 10) $display("unexpected transaction %h", out_data);
                end
                else
                begin
                    if (out_data !== expected_readings[0])
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %h actual %h",
                                     expected_readings[0], out_data);
                    end
                    void'(expected_readings.pop_front());
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_gap = $urandom_range(0, 10);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL modbus_soil_frame_averager");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] counts [6];
        int unsigned n;
        counts = '{3'd7, 3'd3, 3'd4, 3'd0, 3'd6, 3'd7};
        reset_predictor();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, bad crc, zero words, restarts, frame without flag
        queue_frame(7, 2, 1'b0, 1'b1);
        queue_frame(7, 3, 1'b0, 1'b0);
        queue_frame(7, 0, 1'b1, 1'b1);
        queue_noise(3);
        queue_frame(7, 0, 1'b0, 1'b1);
        wait_idle();
        write_count(3'd3);
        queue_frame(3, 0, 1'b0, 1'b1);
        queue_frame(3, 1, 1'b0, 1'b1);
        wait_idle();

        foreach (counts[ci])
        begin
            write_count(counts[ci]);
            n = regs_active(counts[ci]);
            for (int f = 0; f < 6; f++)
            begin
                case ($urandom_range(0, 9))
                    0: queue_noise($urandom_range(1, 6));
                    1: queue_frame(n, 0, 1'b1, 1'b1);
                    2: queue_frame(n, 1, 1'b0, 1'b1);
                    3: queue_frame(n, 2, 1'b0, 1'b1);
                    default: queue_frame(n, 0, 1'b0, $urandom_range(0, 1));
                endcase
            end
            // pause until every reading has come, then resume
            if (ci == 2)
            begin
                hold_sender = 1'b1;
                while (expected_readings.size() != 0 || in_valid) @(posedge clk);
                hold_sender = 1'b0;
            end
            if (ci == 5) quiet = 1'b1;
            wait_idle();
        end

        if (errors == 0)
            $display("PASS modbus_soil_frame_averager");
        else
            $display("FAIL modbus_soil_frame_averager");
        $finish;
    end
endmodule

// File: modbus_soil_frame_averager.f
+incdir+sv
sv/msfa_pkg.sv
sv/modbus_soil_frame_averager.sv
tb/modbus_soil_frame_averager_test.sv
